// File: rtl/rssi_average_tx_power_control_unit_assert.svh
// Assertion macros for the RSSI power control block and its checker.
`ifndef RSSI_AVERAGE_TX_POWER_CONTROL_UNIT_ASSERT_SVH
`define RSSI_AVERAGE_TX_POWER_CONTROL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSSI_AVG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rssi_avg: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSSI_AVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rssi_avg: next-cycle check failed");

`endif

// File: rtl/rssi_avg_pkg.sv
`default_nettype none
package rssi_avg_pkg;

    localparam int unsigned WINDOW     = 10;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned LEVEL_W    = 4;
    localparam int unsigned MARGIN_W   = 4;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 16;
    localparam int unsigned M_USED_W   = SAMPLE_W + LEVEL_W + 1;

    localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW);
    localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned THR_W   = SAMPLE_W + 2;

    // Ceiling reciprocal; the shift is wide enough that the quotient is exact
    // for every window sum magnitude.
    localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW) + 1;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_RESET = -8'sd50;
    localparam logic signed [SUM_W-1:0]    SUM_RESET    =
        SUM_W'(-50 * int'(WINDOW));
    localparam logic [LEVEL_W-1:0]         LEVEL_RESET  = 4'd4;

    localparam logic signed [SAMPLE_W-1:0] STRONG_RESET = -8'sd45;
    localparam logic signed [SAMPLE_W-1:0] MEDIUM_RESET = -8'sd60;
    localparam logic signed [SAMPLE_W-1:0] WEAK_RESET   = -8'sd75;
    localparam logic [MARGIN_W-1:0]        MARGIN_RESET = 4'd3;
    localparam logic [LEVEL_W-1:0]         LVL_STRONG_RESET = 4'd0;
    localparam logic [LEVEL_W-1:0]         LVL_MEDIUM_RESET = 4'd4;
    localparam logic [LEVEL_W-1:0]         LVL_WEAK_RESET   = 4'd7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STRONG     = 3'd0,
        CFG_MEDIUM     = 3'd1,
        CFG_WEAK       = 3'd2,
        CFG_MARGIN     = 3'd3,
        CFG_LVL_STRONG = 3'd4,
        CFG_LVL_MEDIUM = 3'd5,
        CFG_LVL_WEAK   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] strong_threshold;
        logic signed [SAMPLE_W-1:0] medium_threshold;
        logic signed [SAMPLE_W-1:0] weak_threshold;
        logic [MARGIN_W-1:0]        margin;
        logic [LEVEL_W-1:0]         level_for_strong;
        logic [LEVEL_W-1:0]         level_for_medium;
        logic [LEVEL_W-1:0]         level_for_weak;
    } cfg_t;

    typedef struct packed {
        logic                       level_changed;
        logic [LEVEL_W-1:0]         power_level;
        logic signed [SAMPLE_W-1:0] average_rssi;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/rssi_avg_level.sv
`default_nettype none
module rssi_avg_level (
    input  wire logic signed [rssi_avg_pkg::SUM_W-1:0]   window_sum,
    input  wire rssi_avg_pkg::cfg_t                      cfg,
    input  wire logic [rssi_avg_pkg::LEVEL_W-1:0]        current_level,
    output rssi_avg_pkg::result_t                        result
);

    logic                                   sum_neg;
    logic [rssi_avg_pkg::SUM_W-1:0]         sum_mag;
    logic [rssi_avg_pkg::PROD_W-1:0]        product;
    logic [rssi_avg_pkg::SUM_W-1:0]         quot;
    logic [rssi_avg_pkg::SAMPLE_W-1:0]      quot_low;
    logic signed [rssi_avg_pkg::SAMPLE_W-1:0] avg;
    logic signed [rssi_avg_pkg::THR_W-1:0]  avg_x;
    logic signed [rssi_avg_pkg::THR_W-1:0]  strong_lim;
    logic signed [rssi_avg_pkg::THR_W-1:0]  medium_lim;
    logic signed [rssi_avg_pkg::THR_W-1:0]  weak_lim;
    logic signed [rssi_avg_pkg::THR_W-1:0]  margin_x;
    logic [rssi_avg_pkg::LEVEL_W-1:0]       level_new;

    // Divide magnitude by the window length, truncating toward zero.
    always_comb
    begin
        sum_neg  = window_sum[rssi_avg_pkg::SUM_W-1];
        sum_mag  = sum_neg ? rssi_avg_pkg::SUM_W'(-window_sum)
                           : rssi_avg_pkg::SUM_W'(window_sum);
        product  = rssi_avg_pkg::PROD_W'(sum_mag) * rssi_avg_pkg::PROD_W'(rssi_avg_pkg::RECIP);
        quot     = rssi_avg_pkg::SUM_W'(product >> rssi_avg_pkg::DIV_SHIFT);
        quot_low = quot[rssi_avg_pkg::SAMPLE_W-1:0];
        avg      = sum_neg ? -$signed(quot_low) : $signed(quot_low);
    end

    always_comb
    begin
        avg_x      = rssi_avg_pkg::THR_W'(avg);
        margin_x   = $signed({{(rssi_avg_pkg::THR_W - rssi_avg_pkg::MARGIN_W){1'b0}},
                              cfg.margin});
        strong_lim = rssi_avg_pkg::THR_W'(cfg.strong_threshold) + margin_x;
        medium_lim = rssi_avg_pkg::THR_W'(cfg.medium_threshold) + margin_x;
        weak_lim   = rssi_avg_pkg::THR_W'(cfg.weak_threshold) - margin_x;

        if (avg_x > strong_lim)
        begin
            level_new = cfg.level_for_strong;
        end
        else if (avg_x > medium_lim)
        begin
            level_new = cfg.level_for_medium;
        end
        else if (avg_x < weak_lim)
        begin
            level_new = cfg.level_for_weak;
        end
        else
        begin
            level_new = current_level;
        end

        result.average_rssi  = avg;
        result.power_level   = level_new;
        result.level_changed = (level_new != current_level);
    end

endmodule
`default_nettype wire

// File: rtl/rssi_average_tx_power_control_unit.sv
// Channel   | Dir | Word bits (lowest first)                              | Handshake
// s_axis    | in  | [7:0] rssi_sample                                     | tvalid/tready
// m_axis    | out | [7:0] average_rssi, [11:8] power_level, [12] changed  | tvalid/tready
// cfg       | in  | cfg_addr selects register, cfg_wdata holds the value  | cfg_we, no wait
//
// One sample per clock sustained while the output accepts results.
// Stage one updates the sample window and running sum, stage two divides the sum
// by the window length and picks the power level into the output register.
// Reset fills every window entry with -50, sets the level to 4 and loads the
// register defaults. A stalled output holds; one further sample is still taken.
`default_nettype none
module rssi_average_tx_power_control_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [7:0] rssi_sample
    input  wire logic [rssi_avg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [7:0] average_rssi, [11:8] power_level, [12] level_changed, [15:13] zero
    output logic [rssi_avg_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [rssi_avg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rssi_avg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    rssi_avg_pkg::cfg_t                              cfg_reg;
    logic signed [rssi_avg_pkg::SAMPLE_W-1:0]        window_reg [rssi_avg_pkg::WINDOW];
    logic [rssi_avg_pkg::SLOT_W-1:0]                 slot_reg;
    logic [rssi_avg_pkg::SLOT_W-1:0]                 slot_next;
    logic signed [rssi_avg_pkg::SUM_W-1:0]           sum_reg;
    logic signed [rssi_avg_pkg::SUM_W-1:0]           sum_next;
    logic                                            s1_valid_reg;
    logic                                            s1_valid_next;
    logic [rssi_avg_pkg::LEVEL_W-1:0]                level_reg;
    logic                                            out_valid_reg;
    logic                                            out_valid_next;
    rssi_avg_pkg::result_t                           out_reg;
    rssi_avg_pkg::result_t                           result;
    logic signed [rssi_avg_pkg::SAMPLE_W-1:0]        sample;
    logic                                            out_free;
    logic                                            in_take;
    logic                                            s2_fire;

    assign sample        = $signed(s_axis_tdata[rssi_avg_pkg::SAMPLE_W-1:0]);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s2_fire       = s1_valid_reg && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rssi_avg_pkg::M_TDATA_W - rssi_avg_pkg::M_USED_W){1'b0}},
                            out_reg};

    always_comb
    begin
        sum_next = sum_reg - rssi_avg_pkg::SUM_W'(window_reg[slot_reg])
                           + rssi_avg_pkg::SUM_W'(sample);
        if (slot_reg == rssi_avg_pkg::SLOT_W'(rssi_avg_pkg::WINDOW - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
        s1_valid_next  = in_take ? 1'b1 : (s2_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s2_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    rssi_avg_level u_level (
        .window_sum    (sum_reg),
        .cfg           (cfg_reg),
        .current_level (level_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strong_threshold <= rssi_avg_pkg::STRONG_RESET;
            cfg_reg.medium_threshold <= rssi_avg_pkg::MEDIUM_RESET;
            cfg_reg.weak_threshold   <= rssi_avg_pkg::WEAK_RESET;
            cfg_reg.margin           <= rssi_avg_pkg::MARGIN_RESET;
            cfg_reg.level_for_strong <= rssi_avg_pkg::LVL_STRONG_RESET;
            cfg_reg.level_for_medium <= rssi_avg_pkg::LVL_MEDIUM_RESET;
            cfg_reg.level_for_weak   <= rssi_avg_pkg::LVL_WEAK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rssi_avg_pkg::CFG_STRONG:
                    cfg_reg.strong_threshold <= $signed(cfg_wdata[rssi_avg_pkg::SAMPLE_W-1:0]);
                rssi_avg_pkg::CFG_MEDIUM:
                    cfg_reg.medium_threshold <= $signed(cfg_wdata[rssi_avg_pkg::SAMPLE_W-1:0]);
                rssi_avg_pkg::CFG_WEAK:
                    cfg_reg.weak_threshold <= $signed(cfg_wdata[rssi_avg_pkg::SAMPLE_W-1:0]);
                rssi_avg_pkg::CFG_MARGIN:
                    cfg_reg.margin <= cfg_wdata[rssi_avg_pkg::MARGIN_W-1:0];
                rssi_avg_pkg::CFG_LVL_STRONG:
                    cfg_reg.level_for_strong <= cfg_wdata[rssi_avg_pkg::LEVEL_W-1:0];
                rssi_avg_pkg::CFG_LVL_MEDIUM:
                    cfg_reg.level_for_medium <= cfg_wdata[rssi_avg_pkg::LEVEL_W-1:0];
                rssi_avg_pkg::CFG_LVL_WEAK:
                    cfg_reg.level_for_weak <= cfg_wdata[rssi_avg_pkg::LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage one: replace the oldest sample and advance the running sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(rssi_avg_pkg::WINDOW); i++)
            begin
                window_reg[i] <= rssi_avg_pkg::SAMPLE_RESET;
            end
            slot_reg     <= '0;
            sum_reg      <= rssi_avg_pkg::SUM_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                window_reg[slot_reg] <= sample;
                slot_reg             <= slot_next;
                sum_reg              <= sum_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage two: register the average and the chosen level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= rssi_avg_pkg::LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_fire)
            begin
                level_reg <= result.power_level;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_reg <= result;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rssi_avg_checker.sv
`default_nettype none
`include "rssi_average_tx_power_control_unit_assert.svh"
module rssi_avg_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [rssi_avg_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    logic [rssi_avg_pkg::LEVEL_W-1:0] last_level_reg;
    logic [rssi_avg_pkg::LEVEL_W-1:0] last_level_next;
    logic [1:0]                       inflight_reg;
    logic [1:0]                       inflight_next;
    logic                             in_word;
    logic                             out_word;
    logic                             out_stall;
    logic [rssi_avg_pkg::LEVEL_W-1:0] out_level;
    logic                             out_changed;

    assign in_word     = s_axis_tvalid && s_axis_tready;
    assign out_word    = m_axis_tvalid && m_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_level   = m_axis_tdata[rssi_avg_pkg::SAMPLE_W +: rssi_avg_pkg::LEVEL_W];
    assign out_changed = m_axis_tdata[rssi_avg_pkg::SAMPLE_W + rssi_avg_pkg::LEVEL_W];

    always_comb
    begin
        last_level_next = out_word ? out_level : last_level_reg;
        inflight_next   = inflight_reg + 2'(in_word) - 2'(out_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= rssi_avg_pkg::LEVEL_RESET;
            inflight_reg   <= '0;
        end
        else
        begin
            last_level_reg <= last_level_next;
            inflight_reg   <= inflight_next;
        end
    end

    `RSSI_AVG_ASSERT_NOW(a_changed_flag, out_word, out_changed == (out_level != last_level_reg))
    `RSSI_AVG_ASSERT_NOW(a_no_invented_word, m_axis_tvalid, inflight_reg != 2'd0)
    `RSSI_AVG_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_reg != 2'd3)
    `RSSI_AVG_ASSERT_NEXT(a_stall_holds, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind rssi_average_tx_power_control_unit rssi_avg_checker u_rssi_avg_checker (.*);
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
    import rssi_avg_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 75;
    localparam int SCRIPT_ROWS = 24;

    typedef struct {
        logic signed [SAMPLE_W-1:0] rssi;
        bit                         typed;
        result_t                    want;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor state
    cfg_t                       model_cfg;
    logic signed [SAMPLE_W-1:0] rssi_window [WINDOW];
    int                         fill_slot;
    logic [LEVEL_W-1:0]         model_level;

    result_t     pending_results [$];
    script_row_t script [SCRIPT_ROWS];
    result_t     observed_res;
    result_t     wanted_res;

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int burst_left = 0;
    int burst_target = -50;

    rssi_average_tx_power_control_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void model_write(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_STRONG:     model_cfg.strong_threshold = data;
            CFG_MEDIUM:     model_cfg.medium_threshold = data;
            CFG_WEAK:       model_cfg.weak_threshold = data;
            CFG_MARGIN:     model_cfg.margin = data[MARGIN_W-1:0];
            CFG_LVL_STRONG: model_cfg.level_for_strong = data[LEVEL_W-1:0];
            CFG_LVL_MEDIUM: model_cfg.level_for_medium = data[LEVEL_W-1:0];
            CFG_LVL_WEAK:   model_cfg.level_for_weak = data[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t average_and_decide(input logic signed [SAMPLE_W-1:0] s);
        int total;
        int mean;
        int strong_lim;
        int medium_lim;
        int weak_lim;
        logic [LEVEL_W-1:0] chosen;
        result_t r;
        rssi_window[fill_slot] = s;
        fill_slot = (fill_slot + 1 >= WINDOW) ? 0 : fill_slot + 1;
        total = 0;
        foreach (rssi_window[i])
            total += rssi_window[i];
        mean = total / int'(WINDOW);
        strong_lim = int'($signed(model_cfg.strong_threshold)) + int'(model_cfg.margin);
        medium_lim = int'($signed(model_cfg.medium_threshold)) + int'(model_cfg.margin);
        weak_lim   = int'($signed(model_cfg.weak_threshold)) - int'(model_cfg.margin);
        chosen = model_level;
        if (mean > strong_lim)
            chosen = model_cfg.level_for_strong;
        else if (mean > medium_lim)
            chosen = model_cfg.level_for_medium;
        else if (mean < weak_lim)
            chosen = model_cfg.level_for_weak;
        r.average_rssi  = mean[SAMPLE_W-1:0];
        r.power_level   = chosen;
        r.level_changed = (chosen != model_level);
        model_level = chosen;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] next_rssi();
        int v;
        if ($urandom_range(99) < 15)
            return SAMPLE_W'($urandom_range(255));
        if (burst_left == 0)
        begin
            burst_target = int'($urandom_range(140)) - 130;
            burst_left = $urandom_range(15, 3);
        end
        burst_left--;
        v = burst_target + int'($urandom_range(8)) - 4;
        if (v < -128)
            v = -128;
        if (v > 127)
            v = 127;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, output result_t predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = average_and_decide(s);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        model_write(addr, data);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(CFG_STRONG, c.strong_threshold);
        write_reg(CFG_MEDIUM, c.medium_threshold);
        write_reg(CFG_WEAK, c.weak_threshold);
        // junk in the upper bits of the narrow registers
        write_reg(CFG_MARGIN, {4'($urandom_range(15)), c.margin});
        write_reg(CFG_LVL_STRONG, {4'($urandom_range(15)), c.level_for_strong});
        write_reg(CFG_LVL_MEDIUM, {4'($urandom_range(15)), c.level_for_medium});
        write_reg(CFG_LVL_WEAK, {4'($urandom_range(15)), c.level_for_weak});
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(255)));
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t phase_setting(input int p);
        cfg_t c;
        c.strong_threshold = SAMPLE_W'(-int'($urandom_range(128)));
        c.medium_threshold = SAMPLE_W'(-int'($urandom_range(128)));
        c.weak_threshold   = SAMPLE_W'(-int'($urandom_range(128)));
        c.margin           = MARGIN_W'($urandom_range(15));
        c.level_for_strong = LEVEL_W'($urandom_range(15));
        c.level_for_medium = LEVEL_W'($urandom_range(15));
        c.level_for_weak   = LEVEL_W'($urandom_range(15));
        case (p)
            1:
            begin
                c.strong_threshold = 8'sd0;
                c.medium_threshold = 8'sd0;
                c.weak_threshold   = 8'sd0;
                c.margin           = 4'd15;
                c.level_for_strong = 4'd15;
                c.level_for_medium = 4'd9;
                c.level_for_weak   = 4'd0;
            end
            2:
            begin
                c.strong_threshold = -8'sd128;
                c.medium_threshold = -8'sd128;
                c.weak_threshold   = -8'sd128;
                c.margin           = 4'd0;
                c.level_for_strong = 4'd0;
                c.level_for_medium = 4'd15;
                c.level_for_weak   = 4'd15;
            end
            3:
            begin
                // inverted order: strong lowest, weak highest
                c.strong_threshold = -8'sd90;
                c.medium_threshold = -8'sd40;
                c.weak_threshold   = -8'sd30;
                c.margin           = 4'd2;
            end
            4:
            begin
                c.level_for_strong = 4'd5;
                c.level_for_medium = 4'd5;
                c.level_for_weak   = 4'd5;
            end
            default: ;
        endcase
        return c;
    endfunction

    // receiver
    initial
    begin
        forever
        begin
            if (hold_asked != hold_done)
            begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_done++;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            observed_res = m_axis_tdata[M_USED_W-1:0];
            if (pending_results.size() == 0)
                report_mismatch("word with nothing pending", int'(observed_res), 0);
            else
            begin
                wanted_res = pending_results.pop_front();
                if (observed_res.average_rssi !== wanted_res.average_rssi)
                    report_mismatch("average_rssi", int'($signed(observed_res.average_rssi)),
                                    int'($signed(wanted_res.average_rssi)));
                if (observed_res.power_level !== wanted_res.power_level)
                    report_mismatch("power_level", int'(observed_res.power_level),
                                    int'(wanted_res.power_level));
                if (observed_res.level_changed !== wanted_res.level_changed)
                    report_mismatch("level_changed", int'(observed_res.level_changed),
                                    int'(wanted_res.level_changed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        result_t r;
        model_cfg = '{strong_threshold: STRONG_RESET, medium_threshold: MEDIUM_RESET,
                      weak_threshold: WEAK_RESET, margin: MARGIN_RESET,
                      level_for_strong: LVL_STRONG_RESET, level_for_medium: LVL_MEDIUM_RESET,
                      level_for_weak: LVL_WEAK_RESET};
        foreach (rssi_window[i])
            rssi_window[i] = SAMPLE_RESET;
        fill_slot = 0;
        model_level = LEVEL_RESET;

        script[0] = '{rssi: -8'sd50, typed: 1'b1,
                      want: '{level_changed: 1'b0, power_level: 4'd4, average_rssi: -8'sd50}};
        script[1] = '{rssi: 8'sd127, typed: 1'b1,
                      want: '{level_changed: 1'b1, power_level: 4'd0, average_rssi: -8'sd32}};
        script[2] = '{rssi: -8'sd128, typed: 1'b1,
                      want: '{level_changed: 1'b0, power_level: 4'd0, average_rssi: -8'sd40}};
        for (int i = 3; i < 13; i++)
            script[i] = '{rssi: 8'sd127, typed: 1'b0, want: '0};
        for (int i = 13; i < 23; i++)
            script[i] = '{rssi: -8'sd128, typed: 1'b0, want: '0};
        script[23] = '{rssi: -8'sd128, typed: 1'b1,
                       want: '{level_changed: 1'b0, power_level: 4'd7, average_rssi: -8'sd128}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            send_word(script[i].rssi, r);
            pending_results.push_back(script[i].typed ? script[i].want : r);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 57; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            if (p > 0)
                program_regs(phase_setting(p));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // hold the output while words keep coming
                if (p == 4 && n == 20)
                    hold_asked++;
                // pause the input until the pipe is empty
                if (p == 6 && n == 40)
                begin
                    s_axis_tvalid <= 1'b0;
                    drain();
                end
                send_word(next_rssi(), r);
                pending_results.push_back(r);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
